// File: rtl/vilr_pkg.sv
// Shared types and codes for the virtual interrupt list register injector.
// No dependencies; imported by vilr_lr_mem, virtual_irq_list_register_injector and the testbench.
`default_nettype none

package vilr_pkg;

    localparam int ADDR_W = 6;
    localparam int WORD_W = 32;

    typedef enum logic [1:0] {
        OP_INJECT  = 2'd0,
        OP_QUERY   = 2'd1,
        OP_RELEASE = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_BUSY = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // one read and one write port request toward the list register memory
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

`default_nettype wire

// File: rtl/virtual_irq_list_register_injector.sv
// Top level of the virtual interrupt list register injector: sequencer,
// empty-slot map and result register. Depends on vilr_pkg and vilr_lr_mem.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one request word: an op
//   (inject, query pending, release slot) with its interrupt fields. Output
//   channel (o_out_valid / i_out_stall) returns exactly one result word per
//   request. i_cfg_we / i_cfg_wdata write the index of the highest list
//   register in use; write it only while no request is in flight.
// Sequence:
//   Inject and query walk slots 0..n-1, n = min(last_slot_index+1, NUM_SLOTS),
//   one memory read per cycle; the last word read is checked before the scan
//   ends. S_DONE then loads the result register once the output is free, and
//   the next request is taken back in S_IDLE. Release and the unused op skip
//   the scan and go straight from S_IDLE to S_DONE. One request is worked at
//   a time, so an inject write lands before any later read.
// Reset: synchronous, active low. All slots become empty, the register
//   returns to 3 and no result is pending.
// Stall: a finished result holds in the output register while i_out_stall is
//   high; the sequencer waits in its final state and takes no new request.
`default_nettype none

module virtual_irq_list_register_injector #(
    parameter int NUM_SLOTS = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // configuration
    input  wire logic       i_cfg_we,
    input  wire logic [5:0] i_cfg_wdata,
    // request channel
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [1:0] i_op,
    input  wire logic [9:0] i_virq,
    input  wire logic       i_group_one,
    input  wire logic [7:0] i_priority_req,
    input  wire logic       i_hw_backed,
    input  wire logic [9:0] i_phys_id,
    input  wire logic [2:0] i_src_cpu,
    input  wire logic [5:0] i_slot,
    // result channel
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [1:0]      o_status,
    output logic [5:0]      o_used_slot,
    output logic [31:0]     o_lr_word,
    output logic            o_is_pending
);
    import vilr_pkg::*;

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam logic [6:0] NS7 = 7'(NUM_SLOTS);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    // assemble a pending list register word
    function automatic logic [WORD_W-1:0] build_word(
        input logic [9:0] virq,
        input logic       grp,
        input logic [7:0] prio,
        input logic       hw,
        input logic [9:0] pid,
        input logic [2:0] cpu
    );
        logic [WORD_W-1:0] w;
        w        = '0;
        w[9:0]   = virq;
        w[27:24] = prio[7:4];
        w[28]    = 1'b1;
        w[30]    = grp;
        if (hw) begin
            w[31]    = 1'b1;
            w[19:10] = pid;
        end else if (virq < 10'd16) begin
            w[12:10] = cpu;
        end
        return w;
    endfunction

    // control state
    t_state             r_state, n_state;
    logic [5:0]         r_last_slot;
    logic [NUM_SLOTS-1:0] r_empty, n_empty;
    logic [CW-1:0]      r_issue, n_issue;
    logic               r_chk, n_chk;
    logic [IW-1:0]      r_chk_idx, n_chk_idx;
    logic               r_busy_f, n_busy_f;
    logic               r_free_f, n_free_f;
    logic               r_match_f, n_match_f;
    logic               r_out_valid, n_out_valid;

    // request and scan payload
    logic [1:0]         r_op;
    logic [9:0]         r_virq;
    logic               r_grp;
    logic [7:0]         r_prio;
    logic               r_hw;
    logic [9:0]         r_pid;
    logic [2:0]         r_cpu;
    logic [5:0]         r_slot;
    logic [IW-1:0]      r_busy_idx, n_busy_idx;
    logic [IW-1:0]      r_free_idx, n_free_idx;
    logic [IW-1:0]      r_match_idx, n_match_idx;
    logic               r_match_pend, n_match_pend;

    // result register
    logic [1:0]         r_status, n_status;
    logic [5:0]         r_used, n_used;
    logic [WORD_W-1:0]  r_word, n_word;
    logic               r_pend, n_pend;

    logic [6:0]         last_p1;
    logic [CW-1:0]      scan_n;
    logic               in_acc;
    logic               out_free;
    logic               load_out;
    logic [WORD_W-1:0]  mem_q;
    logic [WORD_W-1:0]  chk_word;
    logic [WORD_W-1:0]  new_word;
    logic               rel_ok;
    t_mem_req           mem_req;

    // number of slots that exist and are in use
    assign last_p1 = {1'b0, r_last_slot} + 7'd1;
    assign scan_n  = (last_p1 > NS7) ? CW'(NUM_SLOTS) : CW'(last_p1);

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign load_out   = (r_state == S_DONE) && out_free;

    // an empty slot reads as the zero word
    assign chk_word = r_empty[r_chk_idx] ? '0 : mem_q;
    assign new_word = build_word(r_virq, r_grp, r_prio, r_hw, r_pid, r_cpu);
    assign rel_ok   = ({1'b0, r_slot} < NS7);

    vilr_lr_mem #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_lr_mem (
        .i_clk  (i_clk),
        .i_req  (mem_req),
        .o_rdata(mem_q)
    );

    always_comb begin
        n_state      = r_state;
        n_empty      = r_empty;
        n_issue      = r_issue;
        n_chk        = 1'b0;
        n_chk_idx    = r_chk_idx;
        n_busy_f     = r_busy_f;
        n_busy_idx   = r_busy_idx;
        n_free_f     = r_free_f;
        n_free_idx   = r_free_idx;
        n_match_f    = r_match_f;
        n_match_idx  = r_match_idx;
        n_match_pend = r_match_pend;
        n_status     = r_status;
        n_used       = r_used;
        n_word       = r_word;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid && i_out_stall;

        mem_req       = '0;
        mem_req.raddr = ADDR_W'(r_issue);
        mem_req.waddr = ADDR_W'(r_free_idx);
        mem_req.wdata = new_word;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_issue   = '0;
                    n_busy_f  = 1'b0;
                    n_free_f  = 1'b0;
                    n_match_f = 1'b0;
                    if (i_op == OP_INJECT || i_op == OP_QUERY) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                // issue one read per cycle, check the word that came back
                if (r_issue != scan_n) begin
                    mem_req.re = 1'b1;
                    n_chk      = 1'b1;
                    n_chk_idx  = r_issue[IW-1:0];
                    n_issue    = r_issue + CW'(1);
                end
                if (r_chk) begin
                    if (r_op == OP_INJECT) begin
                        if (r_empty[r_chk_idx]) begin
                            if (!r_free_f && !r_busy_f) begin
                                n_free_f   = 1'b1;
                                n_free_idx = r_chk_idx;
                            end
                        end else if (chk_word[9:0] == r_virq && !r_busy_f) begin
                            n_busy_f   = 1'b1;
                            n_busy_idx = r_chk_idx;
                        end
                    end else if (chk_word[9:0] == r_virq && !r_match_f) begin
                        n_match_f    = 1'b1;
                        n_match_idx  = r_chk_idx;
                        n_match_pend = chk_word[28];
                    end
                end
                if (r_issue == scan_n && !r_chk) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (load_out) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    n_status    = ST_DONE;
                    n_used      = '0;
                    n_word      = '0;
                    n_pend      = 1'b0;
                    case (r_op)
                        OP_INJECT: begin
                            if (r_busy_f) begin
                                n_status = ST_BUSY;
                                n_used   = ADDR_W'(r_busy_idx);
                            end else if (!r_free_f) begin
                                n_status = ST_FULL;
                            end else begin
                                // write back the new word, mark the slot taken
                                mem_req.we            = 1'b1;
                                n_empty[r_free_idx]   = 1'b0;
                                n_used                = ADDR_W'(r_free_idx);
                                n_word                = new_word;
                            end
                        end
                        OP_QUERY: begin
                            if (r_match_f) begin
                                n_used = ADDR_W'(r_match_idx);
                                n_pend = r_match_pend;
                            end
                        end
                        OP_RELEASE: begin
                            // drop the slot: empty bit alone makes it read as zero
                            if (rel_ok) begin
                                n_empty[r_slot[IW-1:0]] = 1'b1;
                                n_used                  = r_slot;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last_slot <= 6'd3;
            r_empty     <= '1;
            r_issue     <= '0;
            r_chk       <= 1'b0;
            r_busy_f    <= 1'b0;
            r_free_f    <= 1'b0;
            r_match_f   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_empty     <= n_empty;
            r_issue     <= n_issue;
            r_chk       <= n_chk;
            r_busy_f    <= n_busy_f;
            r_free_f    <= n_free_f;
            r_match_f   <= n_match_f;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_last_slot <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op   <= i_op;
            r_virq <= i_virq;
            r_grp  <= i_group_one;
            r_prio <= i_priority_req;
            r_hw   <= i_hw_backed;
            r_pid  <= i_phys_id;
            r_cpu  <= i_src_cpu;
            r_slot <= i_slot;
        end
        r_chk_idx    <= n_chk_idx;
        r_busy_idx   <= n_busy_idx;
        r_free_idx   <= n_free_idx;
        r_match_idx  <= n_match_idx;
        r_match_pend <= n_match_pend;
        r_status     <= n_status;
        r_used       <= n_used;
        r_word       <= n_word;
        r_pend       <= n_pend;
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_used_slot  = r_used;
    assign o_lr_word    = r_word;
    assign o_is_pending = r_pend;

    // scan pointer never runs past the slots in use
    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_issue <= scan_n)
        else $error("scan pointer past slot count");

    // memory written only by a successful inject at the end of its scan
    a_write_ctx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.we |-> (r_state == S_DONE && r_op == OP_INJECT && r_free_f && !r_busy_f))
        else $error("list register write outside inject completion");

    // a checked read word always follows a read issued during the scan
    a_chk_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk |-> $past(r_state) == S_SCAN)
        else $error("read data checked without a scan read");

    // a result is loaded only while the output register can take it
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_status == $past(r_status)
            && r_word == $past(r_word) && r_used == $past(r_used)))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

// File: rtl/vilr_lr_mem.sv
// List register storage: one write port, one read port, registered read data.
// Depends on vilr_pkg for the request struct and word width.
`default_nettype none

module vilr_lr_mem #(
    parameter int NUM_SLOTS = 4
) (
    input  wire logic                  i_clk,
    input  wire vilr_pkg::t_mem_req    i_req,
    output logic [vilr_pkg::WORD_W-1:0] o_rdata
);
    import vilr_pkg::*;

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic [WORD_W-1:0] r_mem [NUM_SLOTS];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr[IW-1:0]] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr[IW-1:0]];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: tb/virtual_irq_list_register_injector_test.sv
// Self-checking testbench for virtual_irq_list_register_injector: inject, query and
// release words against an in-bench list register predictor, under random idling.
// Depends on vilr_pkg and the injector RTL.
`default_nettype none

module virtual_irq_list_register_injector_test;

    import vilr_pkg::*;

    localparam int LR_SLOTS     = 4;
    localparam int RAND_ITEMS   = 270;    // per configuration phase, six phases
    localparam int STUCK_LIMIT  = 2000;   // cycles with no word moving on either side
    localparam int LONG_HOLD    = 120;    // receiver hold-off used to back up the block
    localparam int END_SETTLE   = 12;
    localparam int SGI_LIMIT    = 16;     // virtual ids below this are SGIs
    localparam int MAX_REPORTS  = 30;

    // op code the block must treat as a no-op
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [9:0] virq;
        logic       group_one;
        logic [7:0] prio;
        logic       hw;
        logic [9:0] phys;
        logic [2:0] cpu;
        logic [5:0] slot;
    } t_irq_req;

    typedef struct packed {
        t_status     status;
        logic [5:0]  used_slot;
        logic [31:0] lr_word;
        logic        is_pending;
    } t_irq_res;

    // ---------------------------------------------------------------- DUT I/O
    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_we       = 1'b0;
    logic [5:0]  i_cfg_wdata    = '0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_op           = '0;
    logic [9:0]  i_virq         = '0;
    logic        i_group_one    = 1'b0;
    logic [7:0]  i_priority_req = '0;
    logic        i_hw_backed    = 1'b0;
    logic [9:0]  i_phys_id      = '0;
    logic [2:0]  i_src_cpu      = '0;
    logic [5:0]  i_slot         = '0;
    logic        o_out_valid;
    logic        i_out_stall    = 1'b0;
    logic [1:0]  o_status;
    logic [5:0]  o_used_slot;
    logic [31:0] o_lr_word;
    logic        o_is_pending;

    virtual_irq_list_register_injector #(
        .NUM_SLOTS(LR_SLOTS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_virq         (i_virq),
        .i_group_one    (i_group_one),
        .i_priority_req (i_priority_req),
        .i_hw_backed    (i_hw_backed),
        .i_phys_id      (i_phys_id),
        .i_src_cpu      (i_src_cpu),
        .i_slot         (i_slot),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_used_slot    (o_used_slot),
        .o_lr_word      (o_lr_word),
        .o_is_pending   (o_is_pending)
    );

    // ------------------------------------------------------- bench state
    t_irq_req    irq_pending_q[$];    // request words not yet taken by the block
    t_irq_res    lr_expect_q[$];      // predicted result words, oldest first

    // shadow copy of the block's list registers, empty map and scan register
    logic [31:0]         lr_shadow[LR_SLOTS];
    logic [LR_SLOTS-1:0] lr_empty;
    logic [5:0]          lr_last_slot;

    int  send_idle_pct = 0;
    int  rx_idle_pct   = 0;
    int  hold_req      = 0;    // bump to ask the receiver for one long hold-off
    int  fail_count    = 0;
    int  stuck_cycles  = 0;
    bit  req_taken     = 1'b0; // request word taken at the last rising edge

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------- predictor
    // Apply one request word to the shadow state and return the result word.
    function automatic t_irq_res lr_predict(t_irq_req r);
        t_irq_res    res;
        int          span;
        int          i;
        int          free_slot;
        bit          found_free;
        bit          busy;
        bit          matched;
        logic [31:0] w;
        res        = '{status: ST_DONE, used_slot: '0, lr_word: '0, is_pending: 1'b0};
        // slots past the physical count never exist, whatever the register says
        span       = (int'(lr_last_slot) + 1 > LR_SLOTS) ? LR_SLOTS : int'(lr_last_slot) + 1;
        free_slot  = 0;
        found_free = 1'b0;
        busy       = 1'b0;
        matched    = 1'b0;
        case (r.op)
            OP_INJECT: begin
                for (i = 0; i < span; i++) begin
                    if (lr_empty[i]) begin
                        if (!found_free) begin
                            found_free = 1'b1;
                            free_slot  = i;
                        end
                    end else if (!busy && lr_shadow[i][9:0] == r.virq) begin
                        busy          = 1'b1;
                        res.used_slot = 6'(i);
                    end
                end
                if (busy) begin
                    res.status = ST_BUSY;
                end else if (!found_free) begin
                    res.status = ST_FULL;
                end else begin
                    w          = '0;
                    w[9:0]     = r.virq;
                    w[29:28]   = 2'b01;          // pending
                    w[30]      = r.group_one;
                    w[27:24]   = r.prio[7:4];
                    if (r.hw) begin
                        w[31]    = 1'b1;
                        w[19:10] = r.phys;
                    end else if (r.virq < SGI_LIMIT) begin
                        w[12:10] = r.cpu;        // SGI records its source cpu
                    end
                    lr_shadow[free_slot] = w;
                    lr_empty[free_slot]  = 1'b0;
                    res.used_slot        = 6'(free_slot);
                    res.lr_word          = w;
                end
            end
            OP_QUERY: begin
                // empty slots match too, by their zeroed word
                for (i = 0; i < span; i++) begin
                    if (!matched && lr_shadow[i][9:0] == r.virq) begin
                        matched        = 1'b1;
                        res.used_slot  = 6'(i);
                        res.is_pending = lr_shadow[i][28];
                    end
                end
            end
            OP_RELEASE: begin
                if (r.slot < LR_SLOTS) begin
                    lr_shadow[r.slot] = '0;
                    lr_empty[r.slot]  = 1'b1;
                    res.used_slot     = r.slot;
                end
            end
            default: ;   // unused op: no state change, all zero
        endcase
        return res;
    endfunction

    function automatic void note_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endfunction

    function automatic t_irq_req lr_req(logic [1:0] op, logic [9:0] virq, logic grp,
                                        logic [7:0] prio, logic hw, logic [9:0] phys,
                                        logic [2:0] cpu, logic [5:0] slot);
        t_irq_req r;
        r = '{op: op, virq: virq, group_one: grp, prio: prio, hw: hw, phys: phys,
              cpu: cpu, slot: slot};
        return r;
    endfunction

    // Mostly traffic on a small id pool and the real slots, so that busy,
    // full and query hits come often; the rest spans the whole field ranges.
    function automatic t_irq_req lr_random_req();
        t_irq_req r;
        int       pick;
        r.group_one = 1'($urandom_range(1));
        r.prio      = 8'($urandom_range(255));
        r.hw        = 1'($urandom_range(1));
        r.phys      = 10'($urandom_range(1023));
        r.cpu       = 3'($urandom_range(7));
        r.virq      = ($urandom_range(9) < 7) ? 10'($urandom_range(20))
                                              : 10'($urandom_range(1023));
        r.slot      = ($urandom_range(9) < 8) ? 6'($urandom_range(LR_SLOTS - 1))
                                              : 6'($urandom_range(63));
        pick        = $urandom_range(99);
        if (pick < 45)
            r.op = OP_INJECT;
        else if (pick < 70)
            r.op = OP_QUERY;
        else if (pick < 96)
            r.op = OP_RELEASE;
        else
            r.op = OP_UNUSED;
        return r;
    endfunction

    // ------------------------------------------------------- driver
    // Hold a word while it waits; otherwise offer the next one or idle.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !req_taken) begin
                // hold: payload stays put until taken
            end else if (irq_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_op           <= irq_pending_q[0].op;
                i_virq         <= irq_pending_q[0].virq;
                i_group_one    <= irq_pending_q[0].group_one;
                i_priority_req <= irq_pending_q[0].prio;
                i_hw_backed    <= irq_pending_q[0].hw;
                i_phys_id      <= irq_pending_q[0].phys;
                i_src_cpu      <= irq_pending_q[0].cpu;
                i_slot         <= irq_pending_q[0].slot;
                i_in_valid     <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure: random stalls plus an occasional long hold-off.
    always @(negedge i_clk) begin
        int hold_left;
        int hold_seen;
        if (i_rst_n) begin
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    // ------------------------------------------------------- monitor
    // Predict from the word actually taken; check each result word in order.
    always @(posedge i_clk) begin
        t_irq_res want;
        if (i_rst_n) begin
            req_taken = i_in_valid && !o_in_stall;
            if (req_taken) begin
                lr_expect_q.push_back(lr_predict(lr_req(i_op, i_virq, i_group_one,
                    i_priority_req, i_hw_backed, i_phys_id, i_src_cpu, i_slot)));
                void'(irq_pending_q.pop_front());
            end
            if (o_out_valid && !i_out_stall) begin
                if (lr_expect_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: result word with none expected, expected none, actual %0h",
                                 $time, {o_status, o_used_slot, o_lr_word, o_is_pending});
                end else begin
                    want = lr_expect_q.pop_front();
                    note_field("status", 32'(want.status), 32'(o_status));
                    note_field("used_slot", 32'(want.used_slot), 32'(o_used_slot));
                    note_field("lr_word", want.lr_word, o_lr_word);
                    note_field("is_pending", 32'(want.is_pending), 32'(o_is_pending));
                end
            end
        end
    end

    // Watchdog: give up when nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------- sequence
    task automatic lr_cfg_write(logic [5:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        lr_last_slot = v;
    endtask

    // Wait until every word has been taken and every result has come back.
    task automatic lr_drain();
        while (irq_pending_q.size() != 0 || lr_expect_q.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int          phase;
        int          k;
        logic [5:0]  cfg_plan[6];
        for (k = 0; k < LR_SLOTS; k++)
            lr_shadow[k] = '0;
        lr_empty     = '1;
        lr_last_slot = 6'd3;
        cfg_plan     = '{6'd3, 6'd0, 6'd63, 6'd1, 6'd2, 6'($urandom_range(62, 4))};

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words at the reset scan setting: fill every slot, SGI cpu
        // recording at both sides of the SGI boundary, HW words at the field
        // extremes, full, busy, query hit / miss / zeroed slot, releases out
        // of range and the unused op.
        irq_pending_q.push_back(lr_req(OP_INJECT, 10'd5, 1'b1, 8'hff, 1'b0, 10'd0, 3'd7, 6'd0));
        irq_pending_q.push_back(lr_req(OP_INJECT, 10'd15, 1'b0, 8'h0f, 1'b0, 10'd0, 3'd3, 6'd0));
        irq_pending_q.push_back(lr_req(OP_INJECT, 10'd16, 1'b1, 8'h80, 1'b0, 10'd0, 3'd7, 6'd0));
        irq_pending_q.push_back(lr_req(OP_INJECT, 10'd1023, 1'b0, 8'hf0, 1'b1, 10'd1023, 3'd5,
                                       6'd63));
        irq_pending_q.push_back(lr_req(OP_INJECT, 10'd100, 1'b1, 8'h55, 1'b0, 10'd0, 3'd0, 6'd0));
        irq_pending_q.push_back(lr_req(OP_INJECT, 10'd15, 1'b1, 8'h11, 1'b1, 10'd9, 3'd1, 6'd0));
        irq_pending_q.push_back(lr_req(OP_QUERY, 10'd1023, 1'b0, 8'h00, 1'b0, 10'd0, 3'd0, 6'd0));
        irq_pending_q.push_back(lr_req(OP_QUERY, 10'd7, 1'b0, 8'h00, 1'b0, 10'd0, 3'd0, 6'd0));
        irq_pending_q.push_back(lr_req(OP_RELEASE, 10'd0, 1'b0, 8'h00, 1'b0, 10'd0, 3'd0, 6'd2));
        irq_pending_q.push_back(lr_req(OP_QUERY, 10'd0, 1'b0, 8'h00, 1'b0, 10'd0, 3'd0, 6'd0));
        irq_pending_q.push_back(lr_req(OP_RELEASE, 10'd0, 1'b0, 8'h00, 1'b0, 10'd0, 3'd0, 6'd63));
        irq_pending_q.push_back(lr_req(OP_RELEASE, 10'd0, 1'b0, 8'h00, 1'b0, 10'd0, 3'd0,
                                       6'(LR_SLOTS)));
        irq_pending_q.push_back(lr_req(OP_UNUSED, 10'd1023, 1'b1, 8'hff, 1'b1, 10'd1023, 3'd7,
                                       6'd63));
        irq_pending_q.push_back(lr_req(OP_INJECT, 10'd0, 1'b1, 8'h00, 1'b1, 10'd0, 3'd0, 6'd0));
        irq_pending_q.push_back(lr_req(OP_INJECT, 10'd0, 1'b0, 8'h00, 1'b0, 10'd0, 3'd0, 6'd0));
        irq_pending_q.push_back(lr_req(OP_QUERY, 10'd0, 1'b0, 8'h00, 1'b0, 10'd0, 3'd0, 6'd0));
        for (k = 0; k < LR_SLOTS; k++)
            irq_pending_q.push_back(lr_req(OP_RELEASE, 10'd0, 1'b0, 8'h00, 1'b0, 10'd0, 3'd0,
                                           6'(k)));
        irq_pending_q.push_back(lr_req(OP_INJECT, 10'd3, 1'b0, 8'h70, 1'b1, 10'd512, 3'd6, 6'd0));
        irq_pending_q.push_back(lr_req(OP_QUERY, 10'd3, 1'b0, 8'h00, 1'b0, 10'd0, 3'd0, 6'd0));
        irq_pending_q.push_back(lr_req(OP_QUERY, 10'd1023, 1'b0, 8'h00, 1'b0, 10'd0, 3'd0, 6'd0));
        lr_drain();

        // Random phases, one scan setting each: receiver-heavy idling first, then
        // sender-heavy, then none. Each phase pauses the sender halfway until
        // every result is back; one phase also parks the receiver for a long
        // stretch so the block backs up and stalls its input.
        for (phase = 0; phase < 6; phase++) begin
            lr_cfg_write(cfg_plan[phase]);
            case (phase / 2)
                0:       begin send_idle_pct = 31; rx_idle_pct = 59; end
                1:       begin send_idle_pct = 59; rx_idle_pct = 31; end
                default: begin send_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            for (k = 0; k < RAND_ITEMS / 2; k++)
                irq_pending_q.push_back(lr_random_req());
            if (phase == 4)
                hold_req++;
            lr_drain();
            for (k = RAND_ITEMS / 2; k < RAND_ITEMS; k++)
                irq_pending_q.push_back(lr_random_req());
            lr_drain();
        end

        // let any stray result word show up before judging
        repeat (END_SETTLE) @(posedge i_clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
